// File: hw/rtl/dense_matrix_multiply_defines.svh
// Assertion macros used by the checker file of the matrix multiplier.
`ifndef DENSE_MATRIX_MULTIPLY_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dmm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the matrix multiplier.
package dmm_pkg;

  localparam int MAX_DIM     = 64;
  localparam int IDX_W       = 6;
  localparam int IDX_SPAN    = 1 << IDX_W;
  localparam int DIM_LIMIT   = (MAX_DIM < IDX_SPAN) ? MAX_DIM : IDX_SPAN;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SIZE_W      = 7;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int SUM_W       = 40;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Operation codes of an input transaction.
  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_ROW     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE_A,
    CMD_WRITE_B,
    CMD_ROW
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] elem;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0] n_rows;
    logic [SIZE_W-1:0] n_inner;
    logic [SIZE_W-1:0] n_cols;
  } dims_t;

  // A size of zero acts as one, and sizes above the index range are clipped.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] res;
    if (raw == '0) begin
      res = SIZE_W'(1);
    end else if (raw > SIZE_W'(DIM_LIMIT)) begin
      res = SIZE_W'(DIM_LIMIT);
    end else begin
      res = raw;
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

endpackage

// File: hw/rtl/dmm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
interface dmm_in_if import dmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [ELEM_W-1:0] element;

  modport source (output valid, operation, row_index, col_index, element, input ready);
  modport sink (input valid, operation, row_index, col_index, element, output ready);
endinterface

interface dmm_out_if import dmm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_value;
  logic [IDX_W-1:0]        result_column;
  logic                    last;

  modport source (output valid, sum_value, result_column, last, input ready);
  modport sink (input valid, sum_value, result_column, last, output ready);
endinterface

// File: hw/rtl/dmm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module dmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/dmm_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the execution back end.
module dmm_queue import dmm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: hw/rtl/dmm_front.sv
`timescale 1ns / 1ps
// Front end: takes input items, drops out-of-range or unknown ones, forms commands.
module dmm_front import dmm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  dmm_in_if.sink in_chan_i,
  input  dims_t  dims_i,
  output logic   cmd_valid_o,
  input  logic   cmd_ready_i,
  output cmd_t   cmd_o
);

  logic              stage_valid_q, stage_valid_d;
  cmd_t              stage_cmd_q;
  cmd_t              cmd_new;
  logic              keep;
  logic              accept;
  logic [SIZE_W-1:0] row_ext, col_ext;

  assign in_chan_i.ready = !stage_valid_q || cmd_ready_i;
  assign accept          = in_chan_i.valid && in_chan_i.ready;
  assign row_ext         = SIZE_W'(in_chan_i.row_index);
  assign col_ext         = SIZE_W'(in_chan_i.col_index);

  always_comb begin
    cmd_new.row  = in_chan_i.row_index;
    cmd_new.col  = in_chan_i.col_index;
    cmd_new.elem = in_chan_i.element;
    cmd_new.kind = CMD_ROW;
    keep         = 1'b0;
    unique case (in_chan_i.operation)
      OP_WRITE_A: begin
        cmd_new.kind = CMD_WRITE_A;
        keep         = (row_ext < dims_i.n_rows) && (col_ext < dims_i.n_inner);
      end
      OP_WRITE_B: begin
        cmd_new.kind = CMD_WRITE_B;
        keep         = (row_ext < dims_i.n_inner) && (col_ext < dims_i.n_cols);
      end
      OP_ROW: begin
        cmd_new.kind = CMD_ROW;
        keep         = row_ext < dims_i.n_rows;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (accept) begin
      stage_valid_d = keep;
    end else begin
      stage_valid_d = stage_valid_q && !cmd_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_cmd_q <= cmd_new;
    end
  end

  assign cmd_valid_o = stage_valid_q;
  assign cmd_o       = stage_cmd_q;

endmodule

// File: hw/rtl/dmm_back.sv
`timescale 1ns / 1ps
// Back end: element stores, row sequencer and the shared multiply-accumulate pipeline.
module dmm_back import dmm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  input  dims_t      dims_i,
  dmm_out_if.source  out_chan_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  row_q, k_q, c_q;
  logic [SIZE_W-1:0] nk_q, nc_q;
  logic              pop, start, issue, advance;
  logic              k_last, c_last;
  logic [ELEM_W-1:0] a_data, b_data;
  logic [ADDR_W-1:0] wr_addr;

  // Pipeline tags: stage 1 waits on the store read, stage 2 holds the product.
  logic                     s1_valid_q, s1_first_q, s1_lastk_q, s1_lastc_q;
  logic [IDX_W-1:0]         s1_col_q;
  logic                     s2_valid_q, s2_first_q, s2_lastk_q, s2_lastc_q;
  logic [IDX_W-1:0]         s2_col_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]         acc_q, acc_next, acc_base;

  logic                     out_valid_q;
  logic [SUM_W-1:0]         out_sum_q;
  logic [IDX_W-1:0]         out_col_q;
  logic                     out_last_q;
  logic                     out_load;

  assign advance     = !out_valid_q || out_chan_o.ready;
  assign cmd_ready_o = state_q == ST_IDLE;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign start       = pop && (cmd_i.kind == CMD_ROW);
  assign issue       = (state_q == ST_RUN) && advance;
  assign k_last      = SIZE_W'(k_q) + SIZE_W'(1) == nk_q;
  assign c_last      = SIZE_W'(c_q) + SIZE_W'(1) == nc_q;
  assign wr_addr     = store_addr(cmd_i.row, cmd_i.col);

  dmm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_a_store (
    .clk_i     (clk_i),
    .wr_en_i   (pop && (cmd_i.kind == CMD_WRITE_A)),
    .wr_addr_i (wr_addr),
    .wr_data_i (cmd_i.elem),
    .rd_en_i   (issue),
    .rd_addr_i (store_addr(row_q, k_q)),
    .rd_data_o (a_data)
  );

  dmm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_b_store (
    .clk_i     (clk_i),
    .wr_en_i   (pop && (cmd_i.kind == CMD_WRITE_B)),
    .wr_addr_i (wr_addr),
    .wr_data_i (cmd_i.elem),
    .rd_en_i   (issue),
    .rd_addr_i (store_addr(k_q, c_q)),
    .rd_data_o (b_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && k_last && c_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    acc_base = s2_first_q ? '0 : acc_q;
    acc_next = acc_base + {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    out_load = advance && s2_valid_q && s2_lastk_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (advance) begin
        s1_valid_q <= issue;
        s2_valid_q <= s1_valid_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      row_q <= cmd_i.row;
      k_q   <= '0;
      c_q   <= '0;
      nk_q  <= dims_i.n_inner;
      nc_q  <= dims_i.n_cols;
    end else if (issue) begin
      if (k_last) begin
        k_q <= '0;
        c_q <= c_q + IDX_W'(1);
      end else begin
        k_q <= k_q + IDX_W'(1);
      end
    end
    if (advance) begin
      s1_first_q <= k_q == '0;
      s1_lastk_q <= k_last;
      s1_lastc_q <= c_last;
      s1_col_q   <= c_q;
      s2_first_q <= s1_first_q;
      s2_lastk_q <= s1_lastk_q;
      s2_lastc_q <= s1_lastc_q;
      s2_col_q   <= s1_col_q;
      prod_q     <= $signed(a_data) * $signed(b_data);
      if (s2_valid_q) begin
        acc_q <= acc_next;
      end
    end
    if (out_load) begin
      out_sum_q  <= acc_next;
      out_col_q  <= s2_col_q;
      out_last_q <= s2_lastc_q;
    end
  end

  assign out_chan_o.valid         = out_valid_q;
  assign out_chan_o.sum_value     = out_sum_q;
  assign out_chan_o.result_column = out_col_q;
  assign out_chan_o.last          = out_last_q;

endmodule

// File: hw/rtl/dense_matrix_multiply.sv
`timescale 1ns / 1ps
// Top level of the fixed-point dense matrix multiplier C = A x B.
//
// Load transactions write one Q8.8 element of A or B into its 4096-entry store, one per
// cycle while the command queue has room; a row transaction computes one row of C and
// returns n_cols Q24.16 sums in column order, the final one flagged by last. All products
// of a row go through one shared multiply-accumulate unit that takes one product per cycle
// while the result output is not stalled, and a row request holds the back end, which
// takes no other command, until all its products are issued. A four-entry command queue
// lets loads and requests be taken while a row is being worked on, and out-of-range
// transactions are dropped at the front without a result. The stores are not cleared:
// reading an element that was never written gives an undefined sum. Sizes may only be
// changed while the block is idle.
module dense_matrix_multiply import dmm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dmm_in_if.sink               in_chan_i,
  dmm_out_if.source            out_chan_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  logic [SIZE_W-1:0] a_rows_q, inner_len_q, b_cols_q;
  dims_t             dims;
  logic              f_valid, f_ready, q_valid, q_ready;
  cmd_t              f_cmd, q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q    <= SIZE_W'(1);
      inner_len_q <= SIZE_W'(1);
      b_cols_q    <= SIZE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_A_ROWS:    a_rows_q    <= cfg_data_i;
        REG_INNER_LEN: inner_len_q <= cfg_data_i;
        REG_B_COLS:    b_cols_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dims.n_rows  = eff_size(a_rows_q);
    dims.n_inner = eff_size(inner_len_q);
    dims.n_cols  = eff_size(b_cols_q);
  end

  dmm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan_i   (in_chan_i),
    .dims_i      (dims),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  dmm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  dmm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .dims_i      (dims),
    .out_chan_o  (out_chan_o)
  );

endmodule

// File: hw/rtl/dmm_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the matrix multiplier and its bind to the top level.
`include "dense_matrix_multiply_defines.svh"

module dmm_checker import dmm_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic [OP_W-1:0]      in_operation_i,
  input logic [IDX_W-1:0]     in_row_index_i,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [SIZE_W-1:0]    cfg_data_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [SUM_W-1:0]     out_sum_value_i,
  input logic [IDX_W-1:0]     out_result_column_i,
  input logic                 out_last_i
);

  localparam int PEND_W = 4;

  logic [SIZE_W-1:0] a_rows_q;
  logic [IDX_W-1:0]  exp_col_q;
  logic [PEND_W-1:0] pend_q;
  logic              row_req, row_done, out_acc;

  assign out_acc  = out_valid_i && out_ready_i;
  assign row_done = out_acc && out_last_i;
  assign row_req  = in_valid_i && in_ready_i && (in_operation_i == OP_ROW)
                    && (SIZE_W'(in_row_index_i) < eff_size(a_rows_q));

  // Track the row size, the expected next result column and the number of row requests still owed a final result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q  <= SIZE_W'(1);
      exp_col_q <= '0;
      pend_q    <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == REG_A_ROWS)) begin
        a_rows_q <= cfg_data_i;
      end
      if (out_acc) begin
        exp_col_q <= out_last_i ? '0 : out_result_column_i + IDX_W'(1);
      end
      pend_q <= pend_q + PEND_W'(row_req) - PEND_W'(row_done);
    end
  end

  `DMM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_sum_value_i) && $stable(out_result_column_i) && $stable(out_last_i), "stalled result changed")
  `DMM_ASSERT_NOW(a_col_order, clk_i, rst_ni, out_acc, out_result_column_i == exp_col_q, "result columns out of order")
  `DMM_ASSERT_NOW(a_no_orphan, clk_i, rst_ni, out_valid_i, pend_q != '0, "result without a pending row request")

endmodule

bind dense_matrix_multiply dmm_checker u_dmm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_chan_i.valid),
  .in_ready_i          (in_chan_i.ready),
  .in_operation_i      (in_chan_i.operation),
  .in_row_index_i      (in_chan_i.row_index),
  .cfg_we_i            (cfg_we_i),
  .cfg_index_i         (cfg_index_i),
  .cfg_data_i          (cfg_data_i),
  .out_valid_i         (out_chan_o.valid),
  .out_ready_i         (out_chan_o.ready),
  .out_sum_value_i     (out_chan_o.sum_value),
  .out_result_column_i (out_chan_o.result_column),
  .out_last_i          (out_chan_o.last)
);
